[hw/rtl/smpec_pkg.sv]
// ----------------------------------------------------------------------------
// smpec_pkg
// shared types and constants of the smbus master with pec
// ----------------------------------------------------------------------------
package smpec_pkg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_START = 3'd1,
        ST_TX    = 3'd2,
        ST_ACKW  = 3'd3,
        ST_ACKC  = 3'd4,
        ST_RX    = 3'd5,
        ST_MACK  = 3'd6,
        ST_STOP  = 3'd7
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WORD   = 2'd1,
        OP_RBLOCK = 2'd2,
        OP_WBLOCK = 2'd3
    } t_op;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_LOAD   = 3'd1;
    localparam logic [2:0] MODE_RWORD  = 3'd2;
    localparam logic [2:0] MODE_RBLOCK = 3'd3;
    localparam logic [2:0] MODE_WBLOCK = 3'd4;

    localparam logic [0:0] CFG_ADDR    = 1'd0;
    localparam logic [0:0] CFG_TIMEOUT = 1'd1;

    localparam logic [2:0] STS_OK     = 3'd0;
    localparam logic [2:0] STS_LENGTH = 3'd5;
    localparam logic [2:0] STS_PEC    = 3'd6;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // crc-8 over one byte, eight shift steps
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc ^ v;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/smpec_wbuf.sv]
// ----------------------------------------------------------------------------
// smpec_wbuf
// write block byte buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module smpec_wbuf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/smbus_master_pec_transactions_top.sv]
// ----------------------------------------------------------------------------
// smbus_master_pec_transactions_top
// bit-level smbus master with crc-8 pec, one bus phase per tick word
// ----------------------------------------------------------------------------
// Each accepted input word is one bus tick and yields exactly one output word
// via the output register; a word may be accepted every cycle while o_stall is
// low, and the skid stage holds one more word while the output stalls. A bit
// takes four ticks. The next buffer byte of a write block is prefetched from
// the buffer ram during the ack slot, so the ram read is off the path.
module smbus_master_pec_transactions_top #(
    parameter int MAX_BLOCK_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_command,
    input  logic [6:0]  i_length,
    input  logic [7:0]  i_write_byte,
    input  logic        i_sda_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl,
    output logic        o_sda_release,
    output logic        o_busy_res,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [15:0] o_word_value
);
    import smpec_pkg::*;

    localparam int AW = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
    localparam int PW = $clog2(MAX_BLOCK_BYTES + 1);

    typedef struct packed {
        logic        scl;
        logic        rel;
        logic        busy;
        logic        rv;
        logic [7:0]  rb;
        logic        done;
        logic [2:0]  st;
        logic [15:0] wv;
    } t_res;

    logic [6:0]  r_addr;
    logic [15:0] r_tmo;
    t_state      r_state, n_state;
    logic [1:0]  r_ph, n_ph;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_wait, n_wait;
    t_op         r_op, n_op;
    logic [7:0]  r_cmd, n_cmd;
    logic [6:0]  r_len, n_len;
    logic [15:0] r_word, n_word;
    logic [PW-1:0] r_lp, n_lp;
    logic [2:0]  r_est, n_est;

    t_res r_out, r_skid, res;
    logic r_ovalid, r_svalid;
    logic acc;

    logic we;
    logic [7:0] buf_rd;

    assign o_stall = r_svalid;
    assign acc = i_valid && !o_stall;

    // buffer read address: entry for the byte after the next ack
    logic [7:0] k_next;
    assign k_next = r_byte - 8'd2;
    smpec_wbuf #(.DEPTH(MAX_BLOCK_BYTES), .AW(AW)) u_wbuf (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_lp[AW-1:0]),
        .i_wdata(i_write_byte),
        .i_raddr(k_next[AW-1:0]),
        .o_rdata(buf_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= 7'd11;
            r_tmo  <= 16'd2000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ADDR:    r_addr <= i_cfg_data[6:0];
                CFG_TIMEOUT: r_tmo  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic is_pec(input t_op op, input logic [7:0] bi, input logic [6:0] ln);
        if (op == OP_WORD) return bi == 8'd5;
        return bi == (8'd6 + {1'b0, ln});
    endfunction

    always_comb begin
        logic [1:0] ph;
        logic       last, mid;
        logic [7:0] addr_w, v, k;
        logic [3:0] bi1;
        logic [15:0] w1;
        n_state = r_state; n_ph = r_ph; n_bit = r_bit; n_byte = r_byte;
        n_shift = r_shift; n_crc = r_crc; n_wait = r_wait; n_op = r_op;
        n_cmd = r_cmd; n_len = r_len; n_word = r_word; n_lp = r_lp; n_est = r_est;
        res = '0; res.scl = 1'b1; res.rel = 1'b1;
        we = 1'b0;
        addr_w = {r_addr, 1'b0};
        ph = r_ph;
        last = 1'b0; mid = 1'b0;
        v = r_shift; k = '0; bi1 = '0; w1 = '0;

        if (acc) begin
            if (r_state == ST_IDLE) begin
                if (i_mode == MODE_LOAD) begin
                    if ({1'b0, r_lp} < (PW+1)'(MAX_BLOCK_BYTES)) begin
                        we = 1'b1;
                        n_lp = r_lp + 1'b1;
                    end
                end else if (i_mode == MODE_RWORD || i_mode == MODE_RBLOCK ||
                             i_mode == MODE_WBLOCK) begin
                    if (i_mode != MODE_RWORD && 32'(i_length) > MAX_BLOCK_BYTES) begin
                        res.done = 1'b1;
                    end else begin
                        n_op = t_op'(i_mode[1:0] + 2'd3);
                        n_cmd = i_command; n_len = i_length;
                        n_state = ST_START; n_ph = '0; n_bit = '0; n_byte = '0;
                        n_shift = '0; n_crc = '0; n_wait = '0; n_est = STS_OK;
                        if (i_mode == MODE_RWORD) n_word = '0;
                        if (i_mode == MODE_WBLOCK) n_lp = '0;
                        ph = '0;
                    end
                end
            end
            if (n_state != ST_IDLE) begin
                last = (ph == 2'd3);
                mid  = (ph == 2'd1 || ph == 2'd2);
                res.busy = 1'b1;
                n_ph = ph + 2'd1;
                unique case (n_state)
                    ST_START: begin
                        // scl already low before a repeated start
                        res.scl = (ph == 2'd0) ? (n_byte == 8'd0) : (ph != 2'd3);
                        res.rel = (ph < 2'd2);
                        if (last) begin
                            v = (n_byte == 8'd0) ? addr_w : (addr_w | 8'd1);
                            n_shift = v; n_crc = crc_byte(n_crc, v);
                            n_state = ST_TX; n_bit = '0; n_ph = '0;
                        end
                    end
                    ST_TX: begin
                        res.scl = mid;
                        res.rel = r_shift[3'd7 - r_bit[2:0]];
                        if (last) begin
                            bi1 = r_bit + 4'd1;
                            n_bit = bi1;
                            if (bi1 >= 4'd8) begin
                                n_state = ST_ACKW; n_wait = '0;
                            end
                        end
                    end
                    ST_ACKW: begin
                        res.scl = 1'b0; res.rel = 1'b1; n_ph = '0;
                        if (!i_sda_in) begin
                            n_state = ST_ACKC;
                        end else begin
                            w1 = r_wait + 16'd1;
                            n_wait = w1;
                            if (w1 >= r_tmo) begin
                                n_est = (r_byte >= 8'd3) ? 3'd4 : (r_byte[2:0] + 3'd1);
                                n_state = ST_STOP; n_ph = '0;
                            end
                        end
                    end
                    ST_ACKC: begin
                        res.scl = (ph < 2'd2); res.rel = 1'b1;
                        if (last) begin
                            n_byte = r_byte + 8'd1;
                            if (n_byte == 8'd1 || (r_op == OP_WBLOCK && n_byte == 8'd2)) begin
                                v = (n_byte == 8'd1) ? r_cmd : {1'b0, r_len};
                                n_shift = v; n_crc = crc_byte(r_crc, v);
                                n_state = ST_TX; n_bit = '0; n_ph = '0;
                            end else if (r_op == OP_WBLOCK) begin
                                k = n_byte - 8'd3;
                                if (k < {1'b0, r_len} && 32'(k) < MAX_BLOCK_BYTES) begin
                                    n_shift = buf_rd; n_crc = crc_byte(r_crc, buf_rd);
                                    n_state = ST_TX; n_bit = '0; n_ph = '0;
                                end else begin
                                    n_est = STS_OK; n_state = ST_STOP; n_ph = '0;
                                end
                            end else if (n_byte == 8'd2) begin
                                n_state = ST_START; n_ph = '0;
                            end else begin
                                n_state = ST_RX; n_shift = '0; n_bit = '0; n_ph = '0;
                            end
                        end
                    end
                    ST_RX: begin
                        res.scl = mid; res.rel = 1'b1;
                        if (ph == 2'd1) n_shift = {r_shift[6:0], i_sda_in};
                        if (last) begin
                            bi1 = r_bit + 4'd1;
                            n_bit = bi1;
                            if (bi1 >= 4'd8) begin
                                v = r_shift;
                                n_state = ST_MACK;
                                if (is_pec(r_op, r_byte, r_len)) begin
                                    n_est = (v == r_crc) ? STS_OK : STS_PEC;
                                end else begin
                                    n_crc = crc_byte(r_crc, v);
                                    if (r_op == OP_WORD) begin
                                        if (r_byte == 8'd3) n_word = {r_word[15:8], v};
                                        else n_word = {v, r_word[7:0]};
                                    end else if (r_byte == 8'd3) begin
                                        if (v != ({1'b0, r_len} + 8'd2)) begin
                                            n_est = STS_LENGTH;
                                            n_state = ST_STOP; n_ph = '0;
                                        end
                                    end else begin
                                        res.rv = 1'b1; res.rb = v;
                                    end
                                end
                            end
                        end
                    end
                    ST_MACK: begin
                        res.scl = mid;
                        res.rel = is_pec(r_op, r_byte, r_len);
                        if (last) begin
                            if (is_pec(r_op, r_byte, r_len)) begin
                                n_state = ST_STOP; n_ph = '0;
                            end else begin
                                n_byte = r_byte + 8'd1;
                                n_state = ST_RX; n_shift = '0; n_bit = '0; n_ph = '0;
                            end
                        end
                    end
                    ST_STOP: begin
                        res.scl = (ph != 2'd0);
                        res.rel = (ph >= 2'd2);
                        if (last) begin
                            res.done = 1'b1; res.st = r_est;
                            res.wv = (r_op == OP_WORD) ? r_word : 16'd0;
                            n_state = ST_IDLE; n_ph = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ph <= '0; r_bit <= '0; r_byte <= '0;
            r_shift <= '0; r_crc <= '0; r_wait <= '0; r_op <= OP_NONE;
            r_cmd <= '0; r_len <= '0; r_word <= '0; r_lp <= '0; r_est <= STS_OK;
        end else begin
            r_state <= n_state; r_ph <= n_ph; r_bit <= n_bit; r_byte <= n_byte;
            r_shift <= n_shift; r_crc <= n_crc; r_wait <= n_wait; r_op <= n_op;
            r_cmd <= n_cmd; r_len <= n_len; r_word <= n_word; r_lp <= n_lp;
            r_est <= n_est;
        end
    end

    // output register plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else begin
            if (!r_ovalid || !i_stall) begin
                if (r_svalid) begin
                    r_out <= r_skid; r_ovalid <= 1'b1; r_svalid <= 1'b0;
                end else begin
                    r_out <= res; r_ovalid <= acc;
                end
            end else if (acc) begin
                r_skid <= res; r_svalid <= 1'b1;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_scl         = r_out.scl;
    assign o_sda_release = r_out.rel;
    assign o_busy_res    = r_out.busy;
    assign o_read_valid  = r_out.rv;
    assign o_read_byte   = r_out.rb;
    assign o_done_res    = r_out.done;
    assign o_status      = r_out.st;
    assign o_word_value  = r_out.wv;
endmodule

[dv/smbus_master_pec_transactions_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smbus_master_pec_transactions_top_tb
// drives tick words into the smbus master, predicts every output word and
// checks it field by field; random idle on both sides and one long back-off
// ----------------------------------------------------------------------------
module smbus_master_pec_transactions_top_tb;
    import smpec_pkg::*;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] command;
        logic [6:0] length;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic        scl;
        logic        sda_release;
        logic        busy;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        done;
        logic [2:0]  status;
        logic [15:0] word_value;
    } t_bus;

    localparam int NUM_BYTES = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_ADDR;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = MODE_TICK;
    logic [7:0]  i_command = '0;
    logic [6:0]  i_length = '0;
    logic [7:0]  i_write_byte = '0;
    logic        i_sda_in = 1'b1;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_scl, o_sda_release, o_busy_res, o_read_valid, o_done_res;
    logic [7:0]  o_read_byte;
    logic [2:0]  o_status;
    logic [15:0] o_word_value;

    smbus_master_pec_transactions_top u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [6:0]  p_addr;
    logic [15:0] p_timeout;
    t_state      p_state;
    logic [1:0]  p_phase;
    int unsigned p_bit, p_byte, p_wait;
    logic [7:0]  p_shift, p_crc, p_cmd;
    t_op         p_op;
    logic [6:0]  p_len, p_load_ptr;
    logic [15:0] p_word;
    logic [2:0]  p_end;
    logic [7:0]  p_buf [NUM_BYTES];

    t_tick  pending_ticks[$];
    t_bus   expected_bus[$];
    int     errors = 0;
    bit     hold_off = 1'b0;
    event   hold_go;

    function automatic logic [7:0] crc8(input logic [7:0] c0, input logic [7:0] v);
        logic [7:0] c;
        c = c0 ^ v;
        repeat (8) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        return c;
    endfunction

    function automatic void send_byte(input logic [7:0] v);
        p_shift = v;
        p_crc = crc8(p_crc, v);
        p_state = ST_TX;
        p_bit = 0;
        p_phase = 0;
    endfunction

    function automatic void go_stop(input logic [2:0] s);
        p_end = s;
        p_state = ST_STOP;
        p_phase = 0;
    endfunction

    function automatic void go_rx();
        p_state = ST_RX;
        p_shift = 0;
        p_bit = 0;
        p_phase = 0;
    endfunction

    function automatic bit at_pec();
        if (p_op == OP_WORD) return p_byte == 5;
        return p_byte == 6 + p_len;
    endfunction

    function automatic void master_reset();
        p_addr = 7'd11;
        p_timeout = 16'd2000;
        p_state = ST_IDLE;
        p_phase = 0; p_bit = 0; p_byte = 0; p_wait = 0;
        p_shift = 0; p_crc = 0; p_cmd = 0; p_op = OP_NONE;
        p_len = 0; p_load_ptr = 0; p_word = 0; p_end = STS_OK;
    endfunction

    function automatic t_bus predict_bus(input t_tick t);
        t_bus r;
        logic [1:0] ph;
        bit last, mid;
        int unsigned k;
        logic [7:0] v;
        r = '0;
        r.scl = 1; r.sda_release = 1;
        ph = p_phase;
        last = ph == 3;
        mid = ph == 1 || ph == 2;
        if (p_state == ST_IDLE) begin
            if (t.mode == MODE_LOAD) begin
                if (p_load_ptr < NUM_BYTES) begin
                    p_buf[p_load_ptr] = t.write_byte;
                    p_load_ptr++;
                end
            end else if (t.mode >= MODE_RWORD && t.mode <= MODE_WBLOCK) begin
                if (t.mode != MODE_RWORD && t.length > NUM_BYTES) begin
                    r.done = 1;
                end else begin
                    p_op = t_op'(2'(t.mode - 3'd1));
                    p_cmd = t.command;
                    p_len = t.length;
                    p_state = ST_START;
                    p_phase = 0; p_bit = 0; p_byte = 0; p_shift = 0;
                    p_crc = 0; p_wait = 0; p_end = STS_OK;
                    if (t.mode == MODE_RWORD) p_word = 0;
                    if (t.mode == MODE_WBLOCK) p_load_ptr = 0;
                    ph = 0; last = 0; mid = 0;
                end
            end
        end
        if (p_state != ST_IDLE) begin
            r.busy = 1;
            p_phase = ph + 2'd1;
            case (p_state)
                ST_START: begin
                    r.scl = (ph == 0) ? (p_byte == 0) : (ph != 3);
                    r.sda_release = ph < 2;
                    if (last) send_byte(p_byte == 0 ? {p_addr, 1'b0} : {p_addr, 1'b1});
                end
                ST_TX: begin
                    r.scl = mid;
                    r.sda_release = p_shift[7 - (p_bit & 7)];
                    if (last) begin
                        p_bit++;
                        if (p_bit >= 8) begin
                            p_state = ST_ACKW;
                            p_wait = 0;
                        end
                    end
                end
                ST_ACKW: begin
                    r.scl = 0;
                    p_phase = 0;
                    if (!t.sda_in) begin
                        p_state = ST_ACKC;
                    end else begin
                        p_wait = (p_wait + 1) & 16'hFFFF;
                        if (p_wait >= p_timeout)
                            go_stop(p_byte >= 3 ? 3'd4 : 3'(p_byte + 1));
                    end
                end
                ST_ACKC: begin
                    r.scl = ph < 2;
                    if (last) begin
                        p_byte++;
                        if (p_byte == 1) begin
                            send_byte(p_cmd);
                        end else if (p_op == OP_WBLOCK) begin
                            if (p_byte == 2) begin
                                send_byte({1'b0, p_len});
                            end else begin
                                k = p_byte - 3;
                                if (k < p_len && k < NUM_BYTES) send_byte(p_buf[k]);
                                else go_stop(STS_OK);
                            end
                        end else if (p_byte == 2) begin
                            p_state = ST_START;
                            p_phase = 0;
                        end else begin
                            go_rx();
                        end
                    end
                end
                ST_RX: begin
                    r.scl = mid;
                    if (ph == 1) p_shift = {p_shift[6:0], t.sda_in};
                    if (last) begin
                        p_bit++;
                        if (p_bit >= 8) begin
                            v = p_shift;
                            p_state = ST_MACK;
                            if (at_pec()) begin
                                p_end = (v == p_crc) ? STS_OK : STS_PEC;
                            end else begin
                                p_crc = crc8(p_crc, v);
                                if (p_op == OP_WORD) begin
                                    if (p_byte == 3) p_word[7:0] = v;
                                    else p_word[15:8] = v;
                                end else if (p_byte == 3) begin
                                    if (v != p_len + 2) go_stop(STS_LENGTH);
                                end else begin
                                    r.read_valid = 1;
                                    r.read_byte = v;
                                end
                            end
                        end
                    end
                end
                ST_MACK: begin
                    r.scl = mid;
                    r.sda_release = at_pec();
                    if (last) begin
                        if (at_pec()) go_stop(p_end);
                        else begin
                            p_byte++;
                            go_rx();
                        end
                    end
                end
                default: begin
                    r.scl = ph != 0;
                    r.sda_release = ph >= 2;
                    if (last) begin
                        r.done = 1;
                        r.status = p_end;
                        r.word_value = (p_op == OP_WORD) ? p_word : 16'd0;
                        p_state = ST_IDLE;
                        p_phase = 0;
                    end
                end
            endcase
        end
        return r;
    endfunction

    function automatic int gap_len();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60) return 0;
        if (n < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (i_valid) begin
                    expected_bus.push_back(predict_bus({i_mode, i_command, i_length,
                                                        i_write_byte, i_sda_in}));
                end
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    t_tick t;
                    t = pending_ticks.pop_front();
                    i_valid <= 1'b1;
                    {i_mode, i_command, i_length, i_write_byte, i_sda_in} <= t;
                    src_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver back-off, counted in cycles
    always begin
        @(hold_go);
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor
    int sink_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_bus.size() == 0) begin
                    $error("output word with nothing expected");
                    errors++;
                end else begin
                    t_bus e;
                    e = expected_bus.pop_front();
                    if (o_scl !== e.scl) begin
                        $error("scl exp %0h got %0h", e.scl, o_scl); errors++;
                    end
                    if (o_sda_release !== e.sda_release) begin
                        $error("sda_release exp %0h got %0h", e.sda_release, o_sda_release);
                        errors++;
                    end
                    if (o_busy_res !== e.busy) begin
                        $error("busy_res exp %0h got %0h", e.busy, o_busy_res); errors++;
                    end
                    if (o_read_valid !== e.read_valid) begin
                        $error("read_valid exp %0h got %0h", e.read_valid, o_read_valid);
                        errors++;
                    end
                    if (o_read_byte !== e.read_byte) begin
                        $error("read_byte exp %0h got %0h", e.read_byte, o_read_byte);
                        errors++;
                    end
                    if (o_done_res !== e.done) begin
                        $error("done_res exp %0h got %0h", e.done, o_done_res); errors++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %0h got %0h", e.status, o_status); errors++;
                    end
                    if (o_word_value !== e.word_value) begin
                        $error("word_value exp %0h got %0h", e.word_value, o_word_value);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                i_stall <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                sink_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            end
        end
    end

    // stimulus helpers: each call queues words
    function automatic void put(input logic [2:0] m, input logic [7:0] c,
                                input logic [6:0] l, input logic [7:0] w, input logic s);
        t_tick t;
        t.mode = m; t.command = c; t.length = l; t.write_byte = w; t.sda_in = s;
        pending_ticks.push_back(t);
    endfunction

    function automatic logic junk_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // tick while busy; any mode, requests and loads are ignored then
    function automatic void filler(input logic s);
        put(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 8'($urandom), s);
    endfunction

    // one tick per phase slot; ack slots get a low sda unless a nack is wanted
    function automatic void ack_slot(input bit nack, input int unsigned polls);
        repeat (polls) filler(1'b1);
        if (!nack) begin
            filler(1'b0);
            repeat (4) filler(junk_bit());
        end
    endfunction

    function automatic void rx_byte(input logic [7:0] v);
        for (int b = 7; b >= 0; b--) begin
            filler(junk_bit());
            filler(v[b]);
            filler(junk_bit());
            filler(junk_bit());
        end
        repeat (4) filler(junk_bit());
    endfunction

    function automatic void idle_ticks(input int n);
        repeat (n) put(3'($urandom_range(5, 7) * ($urandom_range(0, 1))), 8'($urandom),
                       7'($urandom), 8'($urandom), junk_bit());
    endfunction

    // full transaction; op 2 word, 3 read block, 4 write block; timeout is current
    function automatic void transaction(input logic [2:0] m, input int unsigned len,
                                        input int nack_at, input bit bad_len,
                                        input bit bad_pec, input logic [6:0] addr,
                                        input int unsigned tmo);
        logic [7:0] crc, v, cmd;
        int unsigned polls, nbytes;
        cmd = 8'($urandom);
        if (m == MODE_WBLOCK)
            for (int i = 0; i < len; i++)
                put(MODE_LOAD, 8'($urandom), 7'($urandom), 8'($urandom), 1'b1);
        put(m, cmd, 7'(len), 8'($urandom), junk_bit());
        repeat (3) filler(junk_bit());
        // header bytes sent by the master: addrW, cmd, (length or addrR)
        nbytes = (m == MODE_WBLOCK) ? 3 + len : 3;
        crc = crc8(crc8(8'h00, {addr, 1'b0}), cmd);
        for (int i = 0; i < nbytes; i++) begin
            if (i == 2 && m != MODE_WBLOCK) begin
                repeat (4) filler(junk_bit());
                crc = crc8(crc, {addr, 1'b1});
            end
            repeat (32) filler(junk_bit());
            polls = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
            if (polls >= tmo) polls = tmo - 1;
            if (nack_at == i) begin
                ack_slot(1'b1, tmo);
                repeat (4) filler(junk_bit());
                return;
            end
            ack_slot(1'b0, polls);
        end
        if (m == MODE_WBLOCK) begin
            repeat (4) filler(junk_bit());
            return;
        end
        if (m == MODE_RWORD) begin
            for (int i = 0; i < 2; i++) begin
                v = 8'($urandom); crc = crc8(crc, v); rx_byte(v);
            end
        end else begin
            v = bad_len ? 8'(len + 3) : 8'(len + 2);
            crc = crc8(crc, v);
            rx_byte(v);
            if (bad_len) begin
                repeat (4) filler(junk_bit());
                return;
            end
            for (int i = 0; i < len + 2; i++) begin
                v = 8'($urandom); crc = crc8(crc, v); rx_byte(v);
            end
        end
        rx_byte(bad_pec ? ~crc : crc);
        repeat (4) filler(junk_bit());
    endfunction

    task automatic drain();
        while (pending_ticks.size() > 0 || expected_bus.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ADDR) p_addr = val[6:0];
        else p_timeout = val;
    endtask

    initial begin
        master_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // loads, oversized blocks, idle ticks, block transactions and their errors
        write_reg(CFG_TIMEOUT, 16'd3);
        idle_ticks(3);
        put(MODE_RBLOCK, 8'hFF, 7'd127, 8'hFF, 1'b1);
        put(MODE_WBLOCK, 8'h00, 7'd65, 8'h00, 1'b0);
        put(3'd7, 8'hFF, 7'h7F, 8'hFF, 1'b1);
        transaction(MODE_WBLOCK, 2, -1, 0, 0, 7'd11, 3);
        transaction(MODE_RBLOCK, 0, -1, 0, 1, 7'd11, 3);
        transaction(MODE_RBLOCK, 0, -1, 1, 0, 7'd11, 3);
        transaction(MODE_WBLOCK, 1, 0, 0, 0, 7'd11, 3);
        drain();

        // read word at the top address, sender keeps pushing under a long back-off
        write_reg(CFG_ADDR, 16'h007F);
        write_reg(CFG_TIMEOUT, 16'd1);
        -> hold_go;
        transaction(MODE_RWORD, 0, -1, 0, 0, 7'h7F, 1);
        drain();

        // address zero, command byte not acknowledged
        write_reg(CFG_ADDR, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd2);
        transaction(MODE_RWORD, 0, 1, 0, 0, 7'h00, 2);
        drain();

        if (errors == 0) begin
            $display("smbus_master_pec_transactions_top: match");
        end else begin
            $display("smbus_master_pec_transactions_top: mismatch");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("smbus_master_pec_transactions_top: mismatch");
        $finish;
    end

endmodule
